// ----- sv/sns_pkg.sv -----
// shared types, constants and register codes of the subband noise suppressor
// used by every module of the block but the generic ram; depends on nothing
package sns_pkg;

    localparam int BANDS_DEF  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int LEVEL_W    = 24;
    localparam int POWER_W    = 48;
    localparam int PROB_W     = 17;
    localparam int ACC_W      = 66;
    localparam int DEN_W      = 49;
    localparam int QUOT_W     = 17;

    localparam logic [16:0] UNITY      = 17'd65536;
    localparam logic [16:0] PROB_INIT  = 17'd32768;
    localparam logic [47:0] EPS_POWER  = 48'd70368744;
    localparam logic [ACC_W-1:0] RND   = ACC_W'(32768);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ATTACK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_RELEASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALLEY_ATTACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALLEY_RISE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEECH_RATIO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_SMOOTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSUBTRACT  = 3'd7;

    typedef struct packed {
        logic [2:0]         band;
        logic signed [15:0] sample;
    } t_in;

    typedef struct packed {
        logic [2:0]         band_out;
        logic signed [15:0] enhanced_sample;
        logic [16:0]        gain;
        logic               speech_flag;
    } t_out;

    typedef struct packed {
        logic [15:0] peak_attack_coeff;
        logic [15:0] peak_release_coeff;
        logic [15:0] valley_attack_coeff;
        logic [16:0] valley_rise_gain;
        logic [7:0]  speech_ratio;
        logic [15:0] prob_smooth_coeff;
        logic [15:0] noise_floor_coeff;
        logic [15:0] oversubtract_factor;
    } t_cfg;

    // one band's stored state
    typedef struct packed {
        logic [PROB_W-1:0]  prob;
        logic [POWER_W-1:0] noise;
        logic [LEVEL_W-1:0] valley;
        logic [LEVEL_W-1:0] peak;
    } t_entry;

endpackage

// ----- sv/sns_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module sns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sns_cfg_regs.sv -----
// configuration register file of the noise suppressor
// depends on sns_pkg
module sns_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sns_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sns_pkg::t_cfg                    o_cfg
);

    sns_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_attack_coeff   <= 16'd64185;
            r_cfg.peak_release_coeff  <= 16'd65454;
            r_cfg.valley_attack_coeff <= 16'd65127;
            r_cfg.valley_rise_gain    <= 17'd65577;
            r_cfg.speech_ratio        <= 8'd10;
            r_cfg.prob_smooth_coeff   <= 16'd65127;
            r_cfg.noise_floor_coeff   <= 16'd65516;
            r_cfg.oversubtract_factor <= 16'd26214;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sns_pkg::REG_PEAK_ATTACK:   r_cfg.peak_attack_coeff   <= i_cfg_data[15:0];
                sns_pkg::REG_PEAK_RELEASE:  r_cfg.peak_release_coeff  <= i_cfg_data[15:0];
                sns_pkg::REG_VALLEY_ATTACK: r_cfg.valley_attack_coeff <= i_cfg_data[15:0];
                sns_pkg::REG_VALLEY_RISE:   r_cfg.valley_rise_gain    <= i_cfg_data[16:0];
                sns_pkg::REG_SPEECH_RATIO:  r_cfg.speech_ratio        <= i_cfg_data[7:0];
                sns_pkg::REG_PROB_SMOOTH:   r_cfg.prob_smooth_coeff   <= i_cfg_data[15:0];
                sns_pkg::REG_NOISE_FLOOR:   r_cfg.noise_floor_coeff   <= i_cfg_data[15:0];
                sns_pkg::REG_OVERSUBTRACT:  r_cfg.oversubtract_factor <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/sns_divider.sv -----
// restoring divider for the gain quotient, one quotient bit per cycle
// depends on sns_pkg
module sns_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sns_pkg::ACC_W-1:0]      i_num,
    input  logic [sns_pkg::DEN_W-1:0]      i_den,
    output logic                           o_done,
    output logic [sns_pkg::QUOT_W-1:0]     o_quot
);

    localparam int CW = $clog2(sns_pkg::QUOT_W);

    logic [sns_pkg::ACC_W-1:0]  r_rem, n_rem;
    logic [sns_pkg::ACC_W-1:0]  r_dsh;
    logic [sns_pkg::QUOT_W-1:0] r_q;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy, r_done;
    logic                       take;

    assign take  = r_rem >= r_dsh;
    assign n_rem = take ? r_rem - r_dsh : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(sns_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= sns_pkg::ACC_W'({i_den, {(sns_pkg::QUOT_W-1){1'b0}}});
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[sns_pkg::QUOT_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- sv/subband_noise_suppressor_unit.sv -----
// subband noise suppressor: per-band peak/valley tracking, mcra noise power
// and oversubtraction gain; depends on sns_pkg, sns_ram, sns_cfg_regs, sns_divider
//
// usage: a word on the input channel carries a band index and a signed q15
// sample; the output channel returns one word per input word, in order, with
// the band index, the gained sample, the q1.16 gain and the speech decision.
// one word is processed at a time. a word for a band in range runs through
// 18 steps of a shared 24x24 multiply-accumulate over the band's state read
// from the state ram, then a bit-serial divider that forms the 17 quotient
// bits of the gain. the first word of a band skips the tracking and noise
// update steps; a zero gain skips the divider. a word whose band is out of
// range passes through unchanged. input ready returns once the result is
// registered; no new word is taken before then. a finished word sits in
// the output register; the block takes the next input word while it waits,
// and holds its own result when the receiver stalls until the register
// frees. synchronous reset clears the control state and marks every band as
// not started; the state ram needs no clearing pass. configuration writes
// are taken on any cycle, intended while idle.
module subband_noise_suppressor_unit #(
    parameter int BANDS = sns_pkg::BANDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sns_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sns_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [sns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sns_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW   = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int EW   = $bits(sns_pkg::t_entry);
    localparam int AC   = sns_pkg::ACC_W;

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001, S_RD   = 24'h000002, S_PK1  = 24'h000004,
        S_PK2  = 24'h000008, S_VL1  = 24'h000010, S_VL2  = 24'h000020,
        S_SQP  = 24'h000040, S_SQV  = 24'h000080, S_RV1  = 24'h000100,
        S_RV2  = 24'h000200, S_PR1  = 24'h000400, S_PR2  = 24'h000800,
        S_B1   = 24'h001000, S_B2   = 24'h002000, S_N1   = 24'h004000,
        S_N2   = 24'h008000, S_N3   = 24'h010000, S_N4   = 24'h020000,
        S_SUB1 = 24'h040000, S_SUB2 = 24'h080000, S_DIV0 = 24'h100000,
        S_DIVW = 24'h200000, S_GM   = 24'h400000, S_DONE = 24'h800000
    } t_state;

    t_state r_state;
    sns_pkg::t_cfg   cfg;
    sns_pkg::t_entry rd_entry, wr_entry;

    logic               r_first, r_ge, r_le, r_flag;
    logic [2:0]         r_band;
    logic signed [15:0] r_s;
    logic [23:0]        r_x, r_pk, r_vl;
    logic [47:0]        r_n, r_p, r_v;
    logic [16:0]        r_pr, r_b, r_g;
    logic signed [18:0] r_y;
    logic [AC-1:0]      r_acc, n_acc;
    logic [BANDS-1:0]   r_valid;
    logic               r_out_valid;
    sns_pkg::t_out      r_out;

    logic               accept, in_range, ram_we, div_start, div_done;
    logic [AW-1:0]      in_addr, cur_addr;
    logic [15:0]        mag;
    logic [23:0]        mul_a, mul_b;
    logic [47:0]        prod;
    logic [AC-1:0]      base, addend;
    logic               sh, use_acc;
    logic [47:0]        n_sel, sub;
    logic [48:0]        den;
    logic [AC-1:0]      div_num;
    logic [16:0]        quot;
    logic signed [33:0] gm_prod;
    logic signed [34:0] gm_sum;
    logic [23:0]        vl_rise;

    sns_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign in_range = 32'(i_in_data.band) < 32'(BANDS);
    assign in_addr  = AW'(i_in_data.band);
    assign cur_addr = AW'(r_band);
    assign mag      = i_in_data.sample[15] ? 16'(-i_in_data.sample)
                                           : 16'(i_in_data.sample);

    assign wr_entry.prob   = r_pr;
    assign wr_entry.noise  = r_n;
    assign wr_entry.valley = r_vl;
    assign wr_entry.peak   = r_pk;
    assign ram_we          = (r_state == S_DIV0);

    sns_ram #(.WIDTH(EW), .DEPTH(BANDS), .AW(AW)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_addr),
        .i_wdata (wr_entry),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (rd_entry)
    );

    assign n_sel   = r_first ? r_p : r_acc[63:16];
    assign sub     = r_acc[63:16];
    assign den     = {1'b0, r_p} + {1'b0, sns_pkg::EPS_POWER};
    assign div_num = AC'({49'(den - {1'b0, sub}), 16'd0}) + AC'(den[48:1]);
    assign div_start = (r_state == S_DIV0) && (den > {1'b0, sub});
    assign vl_rise = (r_acc[47:40] != 8'd0) ? 24'hFFFFFF : r_acc[39:16];

    sns_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // operand selection for the shared multiply-accumulate
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        sh      = 1'b0;
        use_acc = 1'b0;
        base    = '0;
        case (r_state)
            S_PK1: begin
                mul_a = r_ge ? 24'(cfg.peak_attack_coeff) : 24'(cfg.peak_release_coeff);
                mul_b = r_pk;
                base  = sns_pkg::RND;
            end
            S_PK2: begin
                mul_a   = r_ge ? 24'(sns_pkg::UNITY - 17'(cfg.peak_attack_coeff)) : 24'd0;
                mul_b   = r_x;
                use_acc = 1'b1;
            end
            S_VL1: begin
                mul_a = r_le ? 24'(cfg.valley_attack_coeff) : 24'(cfg.valley_rise_gain);
                mul_b = r_vl;
                base  = sns_pkg::RND;
            end
            S_VL2: begin
                mul_a   = r_le ? 24'(sns_pkg::UNITY - 17'(cfg.valley_attack_coeff)) : 24'd0;
                mul_b   = r_x;
                use_acc = 1'b1;
            end
            S_SQP: begin
                mul_a = r_pk;
                mul_b = r_pk;
            end
            S_SQV: begin
                mul_a = r_vl;
                mul_b = r_vl;
            end
            S_RV1: begin
                mul_a = 24'(cfg.speech_ratio);
                mul_b = r_acc[23:0];
            end
            S_RV2: begin
                mul_a   = 24'(cfg.speech_ratio);
                mul_b   = r_v[47:24];
                sh      = 1'b1;
                use_acc = 1'b1;
            end
            S_PR1: begin
                mul_a = 24'(cfg.prob_smooth_coeff);
                mul_b = 24'(r_pr);
                base  = sns_pkg::RND;
            end
            S_PR2: begin
                mul_a   = r_flag ? 24'(sns_pkg::UNITY - 17'(cfg.prob_smooth_coeff)) : 24'd0;
                mul_b   = 24'(sns_pkg::UNITY);
                use_acc = 1'b1;
            end
            S_B1: begin
                mul_a = 24'(cfg.noise_floor_coeff);
                mul_b = 24'(sns_pkg::UNITY);
                base  = sns_pkg::RND;
            end
            S_B2: begin
                mul_a   = 24'(sns_pkg::UNITY - 17'(cfg.noise_floor_coeff));
                mul_b   = 24'(r_pr);
                use_acc = 1'b0;
                base    = sns_pkg::RND + AC'(48'(cfg.noise_floor_coeff) << 16);
            end
            S_N1: begin
                mul_a = 24'(r_acc[32:16]);
                mul_b = r_n[23:0];
                base  = sns_pkg::RND;
            end
            S_N2: begin
                mul_a   = 24'(r_b);
                mul_b   = r_n[47:24];
                sh      = 1'b1;
                use_acc = 1'b1;
            end
            S_N3: begin
                mul_a   = 24'(sns_pkg::UNITY - r_b);
                mul_b   = r_p[23:0];
                use_acc = 1'b1;
            end
            S_N4: begin
                mul_a   = 24'(sns_pkg::UNITY - r_b);
                mul_b   = r_p[47:24];
                sh      = 1'b1;
                use_acc = 1'b1;
            end
            S_SUB1: begin
                mul_a = 24'(cfg.oversubtract_factor);
                mul_b = n_sel[23:0];
            end
            S_SUB2: begin
                mul_a   = 24'(cfg.oversubtract_factor);
                mul_b   = r_n[47:24];
                sh      = 1'b1;
                use_acc = 1'b1;
            end
            default: ;
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign addend = sh ? AC'({prod, 24'd0}) : AC'(prod);
    assign n_acc  = (use_acc ? r_acc : base) + addend;

    assign gm_prod = $signed({1'b0, r_g}) * r_s;
    assign gm_sum  = 35'(gm_prod) + 35'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= in_range ? S_RD : S_GM;
                    end
                end
                S_RD:   r_state <= r_first ? S_SQP : S_PK1;
                S_PK1:  r_state <= S_PK2;
                S_PK2:  r_state <= S_VL1;
                S_VL1:  r_state <= S_VL2;
                S_VL2:  r_state <= S_SQP;
                S_SQP:  r_state <= S_SQV;
                S_SQV:  r_state <= r_first ? S_SUB1 : S_RV1;
                S_RV1:  r_state <= S_RV2;
                S_RV2:  r_state <= S_PR1;
                S_PR1:  r_state <= S_PR2;
                S_PR2:  r_state <= S_B1;
                S_B1:   r_state <= S_B2;
                S_B2:   r_state <= S_N1;
                S_N1:   r_state <= S_N2;
                S_N2:   r_state <= S_N3;
                S_N3:   r_state <= S_N4;
                S_N4:   r_state <= S_SUB1;
                S_SUB1: r_state <= S_SUB2;
                S_SUB2: r_state <= S_DIV0;
                S_DIV0: begin
                    r_valid[cur_addr] <= 1'b1;
                    r_state <= div_start ? S_DIVW : S_GM;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= S_GM;
                    end
                end
                S_GM:   r_state <= S_DONE;
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        case (r_state)
            S_IDLE: begin
                r_band  <= i_in_data.band;
                r_s     <= i_in_data.sample;
                r_x     <= {mag, 8'd0};
                r_flag  <= 1'b0;
                r_g     <= sns_pkg::UNITY;
                r_first <= !r_valid[in_addr];
            end
            S_RD: begin
                if (r_first) begin
                    r_pk <= r_x;
                    r_vl <= r_x;
                    r_pr <= sns_pkg::PROB_INIT;
                end else begin
                    r_pk <= rd_entry.peak;
                    r_vl <= rd_entry.valley;
                    r_pr <= rd_entry.prob;
                    r_n  <= rd_entry.noise;
                end
                r_ge <= r_x >= rd_entry.peak;
                r_le <= r_x <= rd_entry.valley;
            end
            S_VL1: r_pk <= r_acc[39:16];
            S_SQP: begin
                if (!r_first) begin
                    r_vl <= r_le ? r_acc[39:16] : vl_rise;
                end
            end
            S_SQV: r_p  <= r_acc[47:0];
            S_RV1: r_v  <= r_acc[47:0];
            S_PR1: r_flag <= r_p > r_acc[55:0];
            S_B1:  r_pr <= r_acc[32:16];
            S_N1:  r_b  <= r_acc[32:16];
            S_SUB1: r_n <= n_sel;
            S_DIV0: begin
                if (!div_start) begin
                    r_g <= '0;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    r_g <= quot;
                end
            end
            S_GM:  r_y  <= gm_sum[34:16];
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.band_out        <= r_band;
                    r_out.enhanced_sample <= (r_y > 19'sd32767) ? 16'sd32767 : r_y[15:0];
                    r_out.gain            <= r_g;
                    r_out.speech_flag     <= r_flag;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/sns_checker.sv -----
// port-level checks of the noise suppressor output channel
// depends on sns_pkg; bound to subband_noise_suppressor_unit
module sns_checker #(
    parameter int BANDS = sns_pkg::BANDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  sns_pkg::t_out o_out_data
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.gain <= sns_pkg::UNITY)
        else $error("gain above unity");

    // out-of-range band passes through
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (32'(o_out_data.band_out) >= 32'(BANDS))
        |-> o_out_data.gain == sns_pkg::UNITY && !o_out_data.speech_flag)
        else $error("bypass word altered");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.gain == 17'd0 |-> o_out_data.enhanced_sample == 16'sd0)
        else $error("nonzero sample at zero gain");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind subband_noise_suppressor_unit sns_checker #(.BANDS(BANDS)) u_sns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- dv/subband_noise_suppressor_unit_tb.sv -----
// self-checking testbench for subband_noise_suppressor_unit: random and directed
// words through both valid/ready channels, checked against an in-bench predictor;
// depends on sns_pkg and subband_noise_suppressor_unit
module subband_noise_suppressor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBANDS = sns_pkg::BANDS_DEF;
    localparam bit [23:0] LVL_MAX = 24'hFFFFFF;

    logic i_clk, i_rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    sns_pkg::t_in in_data;
    sns_pkg::t_out out_data;
    logic cfg_we;
    logic [sns_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [sns_pkg::CFG_DATA_W-1:0] cfg_data;

    subband_noise_suppressor_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // predictor copy of the registers and the band state
    sns_pkg::t_cfg mdl_cfg;
    bit [23:0] mdl_peak   [NBANDS];
    bit [23:0] mdl_valley [NBANDS];
    bit [47:0] mdl_noise  [NBANDS];
    bit [16:0] mdl_prob   [NBANDS];
    bit        mdl_started[NBANDS];

    sns_pkg::t_in  words_pending[$];
    sns_pkg::t_out results_due[$];
    int   n_accepted = 0;
    int   n_seen = 0;
    bit   failed = 0;
    bit   no_idle = 0;
    bit   sender_pause = 0;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("subband_noise_suppressor_unit regression: fail");
        $finish;
    end

    function automatic bit [95:0] mix(bit [16:0] a, bit [95:0] old_v, bit [95:0] new_v);
        return (96'(a) * old_v + 96'(sns_pkg::UNITY - a) * new_v + 96'd32768) >> 16;
    endfunction

    function automatic sns_pkg::t_out suppress_word(sns_pkg::t_in w);
        sns_pkg::t_out r;
        bit [23:0] x, pk, vl;
        bit [95:0] p, v, n, t, sub, den, g;
        bit [16:0] pr, b;
        bit flag;
        int b_i;
        longint signed s, y;
        s = longint'(w.sample);
        x = 24'((s < 0 ? -s : s) << 8);
        r.band_out = w.band;
        flag = 1'b0;
        if (w.band >= NBANDS) begin
            r.enhanced_sample = w.sample;
            r.gain = sns_pkg::UNITY;
            r.speech_flag = 1'b0;
            return r;
        end
        b_i = int'(w.band);
        if (!mdl_started[b_i]) begin
            pk = x;
            vl = x;
            p = 96'(x) * 96'(x);
            n = p;
            mdl_started[b_i] = 1'b1;
        end else begin
            pk = mdl_peak[b_i];
            vl = mdl_valley[b_i];
            if (x >= pk) pk = 24'(mix(17'(mdl_cfg.peak_attack_coeff), 96'(pk), 96'(x)));
            else pk = 24'((96'(pk) * 96'(mdl_cfg.peak_release_coeff) + 96'd32768) >> 16);
            if (x <= vl) begin
                vl = 24'(mix(17'(mdl_cfg.valley_attack_coeff), 96'(vl), 96'(x)));
            end else begin
                t = (96'(vl) * 96'(mdl_cfg.valley_rise_gain) + 96'd32768) >> 16;
                vl = (t > 96'(LVL_MAX)) ? LVL_MAX : 24'(t);
            end
            p = 96'(pk) * 96'(pk);
            v = 96'(vl) * 96'(vl);
            flag = p > 96'(mdl_cfg.speech_ratio) * v;
            pr = 17'(mix(17'(mdl_cfg.prob_smooth_coeff), 96'(mdl_prob[b_i]),
                         flag ? 96'(sns_pkg::UNITY) : 96'd0));
            mdl_prob[b_i] = pr;
            b = 17'(mix(17'(mdl_cfg.noise_floor_coeff), 96'(sns_pkg::UNITY), 96'(pr)));
            n = mix(b, 96'(mdl_noise[b_i]), p);
        end
        mdl_peak[b_i] = pk;
        mdl_valley[b_i] = vl;
        mdl_noise[b_i] = 48'(n);
        sub = (96'(mdl_cfg.oversubtract_factor) * 96'(mdl_noise[b_i])) >> 16;
        den = p + 96'(sns_pkg::EPS_POWER);
        if (den <= sub) g = 0;
        else g = (((den - sub) << 16) + den / 2) / den;
        if (g > 96'(sns_pkg::UNITY)) g = 96'(sns_pkg::UNITY);
        y = (longint'(g) * s + 32768) >>> 16;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        r.enhanced_sample = 16'(y);
        r.gain = 17'(g);
        r.speech_flag = flag;
        return r;
    endfunction

    // monitor: check finished words, predict accepted ones
    always @(posedge i_clk) begin
        sns_pkg::t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                $error("result word with nothing expected: %p", out_data);
                failed = 1;
            end else begin
                want = results_due.pop_front();
                if (out_data.band_out !== want.band_out) begin
                    $error("band_out: expected %0d, got %0d", want.band_out, out_data.band_out);
                    failed = 1;
                end
                if (out_data.enhanced_sample !== want.enhanced_sample) begin
                    $error("enhanced_sample: expected %0d, got %0d",
                           want.enhanced_sample, out_data.enhanced_sample);
                    failed = 1;
                end
                if (out_data.gain !== want.gain) begin
                    $error("gain: expected %0d, got %0d", want.gain, out_data.gain);
                    failed = 1;
                end
                if (out_data.speech_flag !== want.speech_flag) begin
                    $error("speech_flag: expected %0d, got %0d",
                           want.speech_flag, out_data.speech_flag);
                    failed = 1;
                end
            end
        end
        if (i_rst_n && in_valid && in_ready) begin
            results_due.push_back(suppress_word(in_data));
            n_accepted++;
        end
    end

    // sender
    always @(negedge i_clk) begin
        bit nv;
        sns_pkg::t_in nd;
        nv = in_valid;
        nd = in_data;
        if (n_seen != n_accepted) begin
            n_seen = n_accepted;
            nv = 1'b0;
        end
        if (!nv && !sender_pause && words_pending.size() != 0 &&
            (no_idle || $urandom_range(0, 99) >= 24)) begin
            nv = 1'b1;
            nd = words_pending.pop_front();
        end
        in_valid <= nv;
        in_data <= nd;
    end

    // receiver, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cnt == 0 && hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_idle || ($urandom_range(0, 99) >= 24);
        end
    end

    task automatic wait_idle();
        while (words_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sns_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= sns_pkg::CFG_DATA_W'(val);
        case (idx)
            sns_pkg::REG_PEAK_ATTACK:   mdl_cfg.peak_attack_coeff = 16'(val);
            sns_pkg::REG_PEAK_RELEASE:  mdl_cfg.peak_release_coeff = 16'(val);
            sns_pkg::REG_VALLEY_ATTACK: mdl_cfg.valley_attack_coeff = 16'(val);
            sns_pkg::REG_VALLEY_RISE:   mdl_cfg.valley_rise_gain = 17'(val);
            sns_pkg::REG_SPEECH_RATIO:  mdl_cfg.speech_ratio = 8'(val);
            sns_pkg::REG_PROB_SMOOTH:   mdl_cfg.prob_smooth_coeff = 16'(val);
            sns_pkg::REG_NOISE_FLOOR:   mdl_cfg.noise_floor_coeff = 16'(val);
            sns_pkg::REG_OVERSUBTRACT:  mdl_cfg.oversubtract_factor = 16'(val);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_regs(int unsigned pa, int unsigned pr, int unsigned va,
                             int unsigned vr, int unsigned sr, int unsigned ps,
                             int unsigned nf, int unsigned os);
        wait_idle();
        write_reg(sns_pkg::REG_PEAK_ATTACK, pa);
        write_reg(sns_pkg::REG_PEAK_RELEASE, pr);
        write_reg(sns_pkg::REG_VALLEY_ATTACK, va);
        write_reg(sns_pkg::REG_VALLEY_RISE, vr);
        write_reg(sns_pkg::REG_SPEECH_RATIO, sr);
        write_reg(sns_pkg::REG_PROB_SMOOTH, ps);
        write_reg(sns_pkg::REG_NOISE_FLOOR, nf);
        write_reg(sns_pkg::REG_OVERSUBTRACT, os);
    endtask

    task automatic push_word(int b, int s);
        sns_pkg::t_in w;
        w.band = 3'(b);
        w.sample = 16'(s);
        words_pending.push_back(w);
    endtask

    // bursts of speech-like words on one band, over a noise bed, some stray bands
    task automatic push_random(int count);
        int b, amp, burst;
        b = 0;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 7) == 0) b = $urandom_range(0, NBANDS - 1);
            if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(4, 20);
            if ($urandom_range(0, 29) == 0) begin
                push_word($urandom_range(NBANDS, 7), $urandom_range(0, 65535));
            end else if ($urandom_range(0, 19) == 0) begin
                push_word(b, $urandom_range(0, 65535));
            end else begin
                amp = (burst > 0) ? $urandom_range(2000, 32767) : $urandom_range(0, 400);
                if (burst > 0) burst--;
                push_word(b, $urandom_range(0, 1) ? amp : -amp);
            end
        end
    endtask

    initial begin
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        mdl_cfg = '{peak_attack_coeff: 16'd64185, peak_release_coeff: 16'd65454,
                    valley_attack_coeff: 16'd65127, valley_rise_gain: 17'd65577,
                    speech_ratio: 8'd10, prob_smooth_coeff: 16'd65127,
                    noise_floor_coeff: 16'd65516, oversubtract_factor: 16'd26214};
        for (int k = 0; k < NBANDS; k++) begin
            mdl_peak[k] = '0;
            mdl_valley[k] = '0;
            mdl_noise[k] = '0;
            mdl_prob[k] = sns_pkg::PROB_INIT;
            mdl_started[k] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: first words per band, extremes, silence, out-of-range bands
        push_word(0, -32768);
        push_word(0, 32767);
        push_word(0, 0);
        push_word(0, -1);
        push_word(0, 1);
        push_word(1, 0);
        push_word(1, 0);
        push_word(1, 20000);
        push_word(2, 100);
        push_word(2, 32767);
        push_word(2, -32768);
        push_word(3, 21845);
        push_word(4, -21846);
        push_word(5, 32767);
        push_word(5, 5);
        push_word(6, -32768);
        push_word(7, 32767);
        push_word(6, 0);
        push_word(3, -5);
        push_word(4, 30000);

        // default registers, a stretch with no idle on either channel then long receiver hold-off
        no_idle = 1;
        push_random(60);
        wait_idle();
        no_idle = 0;
        hold_req++;
        push_random(80);
        // sender waits for every result to drain
        while (words_pending.size() > 40) @(posedge i_clk);
        sender_pause = 1;
        while (in_valid || results_due.size() != 0) @(posedge i_clk);
        sender_pause = 0;

        load_regs(0, 0, 0, 65536, 1, 0, 0, 0);
        push_random(100);
        load_regs(65535, 65535, 65535, 131071, 255, 65535, 65535, 65535);
        push_random(100);
        load_regs(50000, 60000, 40000, 98304, 3, 30000, 60000, 65535);
        push_random(100);
        load_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(65536, 131071),
                  $urandom_range(1, 255), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
        push_random(100);
        load_regs(64185, 65454, 65127, 65577, 10, 65127, 65516, 26214);
        push_random(60);

        while (words_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed && results_due.size() == 0) begin
            $display("subband_noise_suppressor_unit regression: pass");
        end else begin
            $display("subband_noise_suppressor_unit regression: fail");
        end
        $finish;
    end
endmodule
